// ===== rtl/integer_pixel_upscaler_assert.svh =====
// ----------------------------------------------------------------------------
// Integer pixel upscaler assertion macros
// Clocked property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PIXEL_UPSCALER_ASSERT_SVH
`define INTEGER_PIXEL_UPSCALER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define IPU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define IPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ipu_pkg.sv =====
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared types and constants of the integer pixel upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ipu_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_SCALE  = 100;

	// register field widths
	localparam int SCALE_W  = 7;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;

	// counter widths
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int REP_W = $clog2(MAX_SCALE);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	localparam int PIX_W = 24;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCALE     = 2'd0,
		REG_IN_WIDTH  = 2'd1,
		REG_IN_HEIGHT = 2'd2
	} cfg_reg_t;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef struct packed {
		logic pad;
		logic row_end;
		logic image_end;
	} out_flags_t;

endpackage

`default_nettype wire

// ===== rtl/integer_pixel_upscaler.sv =====
// ----------------------------------------------------------------------------
// integer_pixel_upscaler
// Nearest-neighbor integer upscaler for 24-bit pixels with row padding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): kind 0 carries a source pixel that is
//   stored in the line buffer, kind 1 is a tick that pulls one output request.
//   Pixels sent while a row is being replayed and ticks sent while a row is
//   still loading are consumed and produce nothing.
//   Output channel (out_valid/out_ready): each request is one replicated pixel
//   or one zero padding byte; row_end and image_end mark row and image ends.
//   A tick's result is registered and is valid in the cycle after the tick is accepted.
//   Throughput: one input request per cycle while the output does not stall;
//   the result register plus the line buffer's registered read port sustain it.
//   Stall: while the result register is full and out_ready is low, in_ready
//   is low and the pending result holds; in_ready rises again in the cycle
//   the receiver takes it.
//   Reset: counters clear, scale/in_width/in_height return to one, and the
//   line buffer contents stay undefined until a row is loaded.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_pixel_upscaler
	import ipu_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   kind,
	input  wire logic [7:0]             blue,
	input  wire logic [7:0]             green,
	input  wire logic [7:0]             red,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [7:0]                  out_blue,
	output logic [7:0]                  out_green,
	output logic [7:0]                  out_red,
	output logic                        is_pad,
	output logic                        row_end,
	output logic                        image_end
);

	logic             accept;
	logic             wr_en;
	logic [COL_W-1:0] wr_addr;
	logic             rd_en;
	logic [COL_W-1:0] rd_addr;
	pixel_t           rd_data;
	logic             emit;
	out_flags_t       flags;
	logic             space;

	assign in_ready = space;
	assign accept   = in_valid && space;

	ipu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.kind      (kind),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.emit      (emit),
		.flags     (flags)
	);

	ipu_line_buf u_line_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({red, green, blue}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ipu_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.emit      (emit),
		.flags     (flags),
		.rd_data   (rd_data),
		.out_ready (out_ready),
		.space     (space),
		.out_valid (out_valid),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.is_pad    (is_pad),
		.row_end   (row_end),
		.image_end (image_end)
	);

endmodule

`default_nettype wire

// ===== rtl/ipu_line_buf.sv =====
// ----------------------------------------------------------------------------
// ipu_line_buf
// One source row of pixels: single write port, registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_line_buf
	import ipu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [COL_W-1:0] wr_addr,
	input  wire pixel_t           wr_data,
	input  wire logic             rd_en,
	input  wire logic [COL_W-1:0] rd_addr,
	output pixel_t                rd_data
);

	pixel_t mem [MAX_WIDTH];
	pixel_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the last read while the output is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/ipu_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipu_ctrl
// Configuration registers and the load / replay counters of the upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_ctrl
	import ipu_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   accept,
	input  wire logic                   kind,
	output logic                        wr_en,
	output logic [COL_W-1:0]            wr_addr,
	output logic                        rd_en,
	output logic [COL_W-1:0]            rd_addr,
	output logic                        emit,
	output out_flags_t                  flags
);

	logic [SCALE_W-1:0]  scale_q;
	logic [WIDTH_W-1:0]  in_width_q;
	logic [HEIGHT_W-1:0] in_height_q;

	logic [COL_W-1:0] load_col_q, load_col_d;
	logic             row_ready_q, row_ready_d;
	logic [COL_W-1:0] read_col_q, read_col_d;
	logic [REP_W-1:0] across_q, across_d;
	logic [1:0]       pad_left_q, pad_left_d;
	logic [REP_W-1:0] down_q, down_d;
	logic [ROW_W-1:0] src_row_q, src_row_d;

	logic [SCALE_W-1:0]  s_eff;
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [1:0]          pad_new;
	logic                row_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_W'(1);
			in_width_q  <= WIDTH_W'(1);
			in_height_q <= HEIGHT_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				REG_IN_WIDTH:  in_width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IN_HEIGHT: in_height_q <= cfg_data[HEIGHT_W-1:0];
				default:       ;
			endcase
		end
	end

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (scale_q == '0)
			s_eff = SCALE_W'(1);
		else if (scale_q > SCALE_W'(MAX_SCALE))
			s_eff = SCALE_W'(MAX_SCALE);
		else
			s_eff = scale_q;

		if (in_width_q == '0)
			w_eff = WIDTH_W'(1);
		else if (in_width_q > WIDTH_W'(MAX_WIDTH))
			w_eff = WIDTH_W'(MAX_WIDTH);
		else
			w_eff = in_width_q;

		if (in_height_q == '0)
			h_eff = HEIGHT_W'(1);
		else if (in_height_q > HEIGHT_W'(MAX_HEIGHT))
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		else
			h_eff = in_height_q;
	end

	// padding bytes of a 3-byte-pixel row equal (width * scale) mod 4
	assign pad_new = 2'(w_eff[1:0] * s_eff[1:0]);

	always_comb begin
		load_col_d  = load_col_q;
		row_ready_d = row_ready_q;
		read_col_d  = read_col_q;
		across_d    = across_q;
		pad_left_d  = pad_left_q;
		down_d      = down_q;
		src_row_d   = src_row_q;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		emit        = 1'b0;
		row_done    = 1'b0;
		flags       = '0;

		if (accept && kind == KIND_PIXEL && !row_ready_q) begin
			wr_en = 1'b1;
			if ({1'b0, load_col_q} + WIDTH_W'(1) >= w_eff) begin
				load_col_d  = '0;
				row_ready_d = 1'b1;
			end else begin
				load_col_d = load_col_q + COL_W'(1);
			end
		end

		if (accept && kind == KIND_TICK && row_ready_q) begin
			emit = 1'b1;
			if (pad_left_q != 2'd0) begin
				flags.pad  = 1'b1;
				pad_left_d = pad_left_q - 2'd1;
				row_done   = (pad_left_q == 2'd1);
			end else begin
				rd_en = 1'b1;
				if ({1'b0, across_q} + (REP_W+1)'(1) >= (REP_W+1)'(s_eff)) begin
					across_d = '0;
					if ({1'b0, read_col_q} + WIDTH_W'(1) >= w_eff) begin
						read_col_d = '0;
						pad_left_d = pad_new;
						row_done   = (pad_new == 2'd0);
					end else begin
						read_col_d = read_col_q + COL_W'(1);
					end
				end else begin
					across_d = across_q + REP_W'(1);
				end
			end

			// advance to the next output row, release the line after the last copy
			if (row_done) begin
				if ({1'b0, down_q} + (REP_W+1)'(1) >= (REP_W+1)'(s_eff)) begin
					down_d      = '0;
					row_ready_d = 1'b0;
					if ({1'b0, src_row_q} + HEIGHT_W'(1) >= h_eff) begin
						src_row_d       = '0;
						flags.image_end = 1'b1;
					end else begin
						src_row_d = src_row_q + ROW_W'(1);
					end
				end else begin
					down_d = down_q + REP_W'(1);
				end
			end
			flags.row_end = row_done;
		end
	end

	assign wr_addr = load_col_q;
	assign rd_addr = read_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q  <= '0;
			row_ready_q <= 1'b0;
			read_col_q  <= '0;
			across_q    <= '0;
			pad_left_q  <= '0;
			down_q      <= '0;
			src_row_q   <= '0;
		end else begin
			load_col_q  <= load_col_d;
			row_ready_q <= row_ready_d;
			read_col_q  <= read_col_d;
			across_q    <= across_d;
			pad_left_q  <= pad_left_d;
			down_q      <= down_d;
			src_row_q   <= src_row_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ipu_out_stage.sv =====
// ----------------------------------------------------------------------------
// ipu_out_stage
// Result register: holds one output request until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_out_stage
	import ipu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       emit,
	input  wire out_flags_t flags,
	input  wire pixel_t     rd_data,
	input  wire logic       out_ready,
	output logic            space,
	output logic            out_valid,
	output logic [7:0]      out_blue,
	output logic [7:0]      out_green,
	output logic [7:0]      out_red,
	output logic            is_pad,
	output logic            row_end,
	output logic            image_end
);

	logic       valid_s1;
	out_flags_t flags_s1;
	pixel_t     pix;

	// stage frees up in the same cycle the receiver takes it
	assign space = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags;
		end
	end

	// padding bytes carry zero color
	assign pix       = flags_s1.pad ? '0 : rd_data;
	assign out_valid = valid_s1;
	assign out_blue  = pix[7:0];
	assign out_green = pix[15:8];
	assign out_red   = pix[23:16];
	assign is_pad    = flags_s1.pad;
	assign row_end   = flags_s1.row_end;
	assign image_end = flags_s1.image_end;

endmodule

`default_nettype wire

// ===== rtl/ipu_checker.sv =====
// ----------------------------------------------------------------------------
// ipu_checker
// Port-level checks of the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_pixel_upscaler_assert.svh"

module ipu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_blue,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_red,
	input wire logic       is_pad,
	input wire logic       row_end,
	input wire logic       image_end
);

	`IPU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(row_end), "output request changed while stalled")
	`IPU_ASSERT_NOW(a_image_row, out_valid && image_end, row_end, "image end without row end")
	`IPU_ASSERT_NOW(a_pad_zero, out_valid && is_pad, out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0, "padding byte with nonzero color")
	`IPU_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input stalled with empty output stage")
	`IPU_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_valid && in_ready), "output request without accepted input")

endmodule

bind integer_pixel_upscaler ipu_checker u_ipu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_blue  (out_blue),
	.out_green (out_green),
	.out_red   (out_red),
	.is_pad    (is_pad),
	.row_end   (row_end),
	.image_end (image_end)
);

`default_nettype wire
